// ----- sv/credit_process_scheduler_top_assert.svh -----
// assertion macros shared by the scheduler modules
`ifndef CREDIT_PROCESS_SCHEDULER_TOP_ASSERT_SVH
`define CREDIT_PROCESS_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define CPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define CPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ----- sv/cps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

    localparam int SLOTS_DEF        = 64;
    localparam int CREDIT_WIDTH_DEF = 16;
    localparam int DEPTH_W          = 8;
    localparam int OP_W             = 3;
    localparam int SLOT_FW          = 6;
    localparam int STATE_FW         = 2;
    localparam int STATUS_W         = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER   = 3'd0,
        OP_SET_STATE  = 3'd1,
        OP_REAP       = 3'd2,
        OP_ENTER_CRIT = 3'd3,
        OP_EXIT_CRIT  = 3'd4,
        OP_SCHEDULE   = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_FULL    = 3'd2,
        ST_REFUSED = 3'd3,
        ST_NORUN   = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [STATE_FW-1:0] {
        RS_UNREADY  = 2'd0,
        RS_STOPPED  = 2'd1,
        RS_RUNNING  = 2'd2,
        RS_AWAITING = 2'd3
    } t_run;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_FW-1:0]  assigned_slot;
        logic [SLOT_FW-1:0]  current_slot;
        logic                switched;
        logic [DEPTH_W-1:0]  critical_depth;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/cps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/cps_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "credit_process_scheduler_top_assert.svh"

module cps_engine #(
    parameter int SLOTS        = cps_pkg::SLOTS_DEF,
    parameter int CREDIT_WIDTH = cps_pkg::CREDIT_WIDTH_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int CW = CREDIT_WIDTH,
    localparam int DW = CW + cps_pkg::DEPTH_W + cps_pkg::STATE_FW + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [cps_pkg::OP_W-1:0]      i_operation,
    input  wire logic [cps_pkg::SLOT_FW-1:0]   i_slot,
    input  wire logic                          i_use_given_slot,
    input  wire logic [cps_pkg::STATE_FW-1:0]  i_new_state,
    input  wire logic                          i_res_free,
    output logic                               o_res_done,
    output cps_pkg::t_result                   o_res,
    output logic                               o_ram_we,
    output logic      [SW-1:0]                 o_ram_waddr,
    output logic      [DW-1:0]                 o_ram_wdata,
    output logic                               o_ram_re,
    output logic      [SW-1:0]                 o_ram_raddr,
    input  wire logic [DW-1:0]                 i_ram_rdata
);

    localparam int DPW = cps_pkg::DEPTH_W;
    localparam logic [CW-1:0]  CREDIT_MAX = {CW{1'b1}};
    localparam logic [DPW-1:0] DEPTH_MAX  = {DPW{1'b1}};

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_INC   = 8'b0010_0000,
        S_RDCUR = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [SW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_cur, n_cur;
    logic          r_pv, n_pv;

    logic [cps_pkg::OP_W-1:0]     r_op, n_op;
    logic [cps_pkg::SLOT_FW-1:0]  r_slot, n_slot;
    logic [cps_pkg::STATE_FW-1:0] r_nst, n_nst;
    logic [cps_pkg::STATUS_W-1:0] r_status, n_status;
    logic [SW-1:0]                r_assigned, n_assigned;
    logic                         r_switched, n_switched;
    logic                         r_free, n_free;
    logic [SW:0]                  r_cnt, n_cnt;
    logic [SW-1:0]                r_paddr, n_paddr;
    logic                         r_found, n_found;
    logic [SW-1:0]                r_best, n_best;
    logic [CW-1:0]                r_bc, n_bc;

    logic                         d_valid;
    logic [cps_pkg::STATE_FW-1:0] d_run;
    logic [CW-1:0]                d_credit;
    logic [DPW-1:0]               d_depth;
    logic [CW-1:0]                inc_credit;
    logic [SW-1:0]                slot_idx;
    logic                         in_ok;
    logic                         issue;
    logic                         scan_end;
    logic                         hit;
    logic                         hit_inc;
    logic [DW-1:0]                new_entry;
    logic [DW-1:0]                boot_entry;

    assign d_valid    = i_ram_rdata[DW-1];
    assign d_run      = i_ram_rdata[DW-2 -: cps_pkg::STATE_FW];
    assign d_credit   = i_ram_rdata[DPW +: CW];
    assign d_depth    = i_ram_rdata[DPW-1:0];
    assign inc_credit = (d_valid && d_credit != CREDIT_MAX) ? d_credit + CW'(1) : d_credit;
    assign slot_idx   = SW'(r_slot);
    assign in_ok      = int'(i_slot) < SLOTS;
    assign issue      = int'(r_cnt) < SLOTS;
    assign scan_end   = !r_pv && (r_cnt == (SW+1)'(SLOTS));
    assign hit        = d_valid && (d_run == cps_pkg::RS_RUNNING)
                        && (!r_found || d_credit > r_bc);
    assign hit_inc    = d_valid && (d_run == cps_pkg::RS_RUNNING)
                        && (!r_found || inc_credit > r_bc);
    assign new_entry  = {1'b1, cps_pkg::RS_STOPPED, {CW{1'b0}}, {DPW{1'b0}}};
    assign boot_entry = {1'b1, cps_pkg::RS_RUNNING, {CW{1'b0}}, {DPW{1'b0}}};

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cur      = r_cur;
        n_pv       = r_pv;
        n_op       = r_op;
        n_slot     = r_slot;
        n_nst      = r_nst;
        n_status   = r_status;
        n_assigned = r_assigned;
        n_switched = r_switched;
        n_free     = r_free;
        n_cnt      = r_cnt;
        n_paddr    = r_paddr;
        n_found    = r_found;
        n_best     = r_best;
        n_bc       = r_bc;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        o_res_done  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                o_ram_wdata = (r_clr == '0) ? boot_entry : '0;
                n_clr       = r_clr + SW'(1);
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_operation;
                    n_slot     = i_slot;
                    n_nst      = i_new_state;
                    n_status   = cps_pkg::ST_OK;
                    n_assigned = '0;
                    n_switched = 1'b0;
                    n_state    = S_RDCUR;
                    case (i_operation)
                        cps_pkg::OP_REGISTER: begin
                            if (i_use_given_slot) begin
                                if (in_ok) begin
                                    n_state = S_RD;
                                end else begin
                                    n_status = cps_pkg::ST_BUSY;
                                end
                            end else begin
                                n_free  = 1'b1;
                                n_cnt   = '0;
                                n_pv    = 1'b0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        cps_pkg::OP_SET_STATE, cps_pkg::OP_REAP: begin
                            if (in_ok) begin
                                n_state = S_RD;
                            end else begin
                                n_status = cps_pkg::ST_EMPTY;
                            end
                        end
                        cps_pkg::OP_ENTER_CRIT, cps_pkg::OP_EXIT_CRIT,
                        cps_pkg::OP_SCHEDULE: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_RDCUR;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_ram_re = 1'b1;
                if (r_op inside {cps_pkg::OP_REGISTER, cps_pkg::OP_SET_STATE,
                                 cps_pkg::OP_REAP}) begin
                    o_ram_raddr = slot_idx;
                end else begin
                    o_ram_raddr = r_cur;
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_RDCUR;
                case (r_op)
                    cps_pkg::OP_REGISTER: begin
                        if (d_valid) begin
                            n_status = cps_pkg::ST_BUSY;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = slot_idx;
                            o_ram_wdata = new_entry;
                            n_assigned  = slot_idx;
                        end
                    end
                    cps_pkg::OP_SET_STATE: begin
                        if (!d_valid) begin
                            n_status = cps_pkg::ST_EMPTY;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = slot_idx;
                            o_ram_wdata = {d_valid, r_nst, d_credit, d_depth};
                        end
                    end
                    cps_pkg::OP_REAP: begin
                        if (!d_valid) begin
                            n_status = cps_pkg::ST_EMPTY;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = slot_idx;
                            o_ram_wdata = {1'b0, i_ram_rdata[DW-2:0]};
                        end
                    end
                    cps_pkg::OP_ENTER_CRIT: begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_cur;
                        o_ram_wdata = {i_ram_rdata[DW-1:DPW],
                                       (d_depth == DEPTH_MAX) ? d_depth : d_depth + DPW'(1)};
                    end
                    cps_pkg::OP_EXIT_CRIT: begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_cur;
                        o_ram_wdata = {i_ram_rdata[DW-1:DPW],
                                       (d_depth == '0) ? d_depth : d_depth - DPW'(1)};
                    end
                    cps_pkg::OP_SCHEDULE: begin
                        if (d_depth != '0) begin
                            n_status = cps_pkg::ST_REFUSED;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_cur;
                            o_ram_wdata = {d_valid, d_run, {CW{1'b0}}, d_depth};
                            n_free      = 1'b0;
                            n_cnt       = '0;
                            n_pv        = 1'b0;
                            n_found     = 1'b0;
                            n_bc        = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_RDCUR;
                    end
                endcase
            end
            S_SCAN: begin
                if (issue) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_cnt[SW-1:0];
                    n_cnt       = r_cnt + (SW+1)'(1);
                end
                n_pv    = issue;
                n_paddr = r_cnt[SW-1:0];
                if (r_free) begin
                    if (r_pv && !d_valid) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_paddr;
                        o_ram_wdata = new_entry;
                        n_assigned  = r_paddr;
                        n_state     = S_RDCUR;
                    end else if (scan_end) begin
                        n_status = cps_pkg::ST_FULL;
                        n_state  = S_RDCUR;
                    end
                end else begin
                    if (r_pv && hit) begin
                        n_found = 1'b1;
                        n_best  = r_paddr;
                        n_bc    = d_credit;
                    end
                    if (scan_end) begin
                        if (!r_found) begin
                            n_status = cps_pkg::ST_NORUN;
                            n_state  = S_RDCUR;
                        end else if (r_bc == '0) begin
                            n_cnt   = '0;
                            n_pv    = 1'b0;
                            n_found = 1'b0;
                            n_state = S_INC;
                        end else begin
                            n_switched = (r_best != r_cur);
                            n_cur      = r_best;
                            n_state    = S_RDCUR;
                        end
                    end
                end
            end
            S_INC: begin
                if (issue) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_cnt[SW-1:0];
                    n_cnt       = r_cnt + (SW+1)'(1);
                end
                n_pv    = issue;
                n_paddr = r_cnt[SW-1:0];
                if (r_pv) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_paddr;
                    o_ram_wdata = {d_valid, d_run, inc_credit, d_depth};
                    if (hit_inc) begin
                        n_found = 1'b1;
                        n_best  = r_paddr;
                        n_bc    = inc_credit;
                    end
                end
                if (scan_end) begin
                    if (r_found) begin
                        n_switched = (r_best != r_cur);
                        n_cur      = r_best;
                    end else begin
                        n_status = cps_pkg::ST_NORUN;
                    end
                    n_state = S_RDCUR;
                end
            end
            S_RDCUR: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_cur;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_res_free) begin
                    o_res_done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_res.status         = r_status;
    assign o_res.assigned_slot  = cps_pkg::SLOT_FW'(r_assigned);
    assign o_res.current_slot   = cps_pkg::SLOT_FW'(r_cur);
    assign o_res.switched       = r_switched;
    assign o_res.critical_depth = d_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cur   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cur   <= n_cur;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_nst      <= n_nst;
        r_status   <= n_status;
        r_assigned <= n_assigned;
        r_switched <= n_switched;
        r_free     <= n_free;
        r_cnt      <= n_cnt;
        r_paddr    <= n_paddr;
        r_found    <= n_found;
        r_best     <= n_best;
        r_bc       <= n_bc;
    end

    `CPS_ASSERT_IMP(a_idle_no_write, r_state == S_IDLE, !o_ram_we)
    `CPS_ASSERT_IMP(a_no_rw_clash, o_ram_we && o_ram_re, o_ram_waddr != o_ram_raddr)
    `CPS_ASSERT_NXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state != S_IDLE)

endmodule

`default_nettype wire

// ----- sv/credit_process_scheduler_top.sv -----
// Credit-based process scheduler. Slot entries (valid, run state, credit, preempt depth) live
// in one dual-port RAM with registered read; one request is worked on at a time. After reset
// a clearing pass through every slot initializes the table (slot zero valid and running) before
// the first request is taken. Set state, reap, enter and exit critical and register with a
// given slot read one entry and, where allowed, write it back. Register with a free-slot search
// steps the RAM read port through the table until a free slot is found or the table ends.
// Schedule steps it once through the table to find the best slot and, when no running slot
// has credit, makes a second pass that adds a credit to every valid slot and picks again. A
// finished result is held in an output register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "credit_process_scheduler_top_assert.svh"

module credit_process_scheduler_top #(
    parameter int SLOTS        = cps_pkg::SLOTS_DEF,
    parameter int CREDIT_WIDTH = cps_pkg::CREDIT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [cps_pkg::OP_W-1:0]      i_operation,
    input  wire logic [cps_pkg::SLOT_FW-1:0]   i_slot,
    input  wire logic                          i_use_given_slot,
    input  wire logic [cps_pkg::STATE_FW-1:0]  i_new_state,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [cps_pkg::STATUS_W-1:0]  o_status,
    output logic      [cps_pkg::SLOT_FW-1:0]   o_assigned_slot,
    output logic      [cps_pkg::SLOT_FW-1:0]   o_current_slot,
    output logic                               o_switched,
    output logic      [cps_pkg::DEPTH_W-1:0]   o_critical_depth
);

    localparam int SW = $clog2(SLOTS);
    localparam int DW = CREDIT_WIDTH + cps_pkg::DEPTH_W + cps_pkg::STATE_FW + 1;

    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic             ram_re;
    logic [SW-1:0]    ram_raddr;
    logic [DW-1:0]    ram_rdata;
    logic             res_free;
    logic             res_done;
    cps_pkg::t_result res;

    logic             r_out_valid;
    cps_pkg::t_result r_out;

    assign res_free = !r_out_valid || i_out_ready;

    cps_engine #(
        .SLOTS        (SLOTS),
        .CREDIT_WIDTH (CREDIT_WIDTH)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_slot           (i_slot),
        .i_use_given_slot (i_use_given_slot),
        .i_new_state      (i_new_state),
        .i_res_free       (res_free),
        .o_res_done       (res_done),
        .o_res            (res),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata)
    );

    cps_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_done) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_assigned_slot  = r_out.assigned_slot;
    assign o_current_slot   = r_out.current_slot;
    assign o_switched       = r_out.switched;
    assign o_critical_depth = r_out.critical_depth;

    `CPS_ASSERT_IMP(a_no_result_overwrite, res_done, !r_out_valid || i_out_ready)

endmodule

`default_nettype wire
